FILE: rtl/fmdds_pkg.sv
package fmdds_pkg;

	localparam int unsigned TABLE_ENTRIES = 256;
	localparam int unsigned INDEX_BITS    = $clog2(TABLE_ENTRIES);
	localparam int unsigned SAMPLE_BITS   = 8;
	localparam int unsigned REG_BITS      = 32;
	localparam int unsigned DEPTH_BITS    = 5;
	localparam int unsigned CFG_IDX_BITS  = 2;

	// register map
	localparam logic [CFG_IDX_BITS-1:0] REG_MOD_INC   = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_CAR_INC   = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_DEPTH     = 2'd2;

	typedef struct packed {
		logic [REG_BITS-1:0]   mod_inc;
		logic [REG_BITS-1:0]   car_inc;
		logic [DEPTH_BITS-1:0] depth;
	} cfg_t;

	typedef logic [TABLE_ENTRIES-1:0][SAMPLE_BITS-1:0] rom_t;

	// table build constants, Q60 fixed point
	localparam logic [63:0] AngleNum = 64'd62832;
	localparam logic [63:0] Den      = 64'd10000 * 64'(TABLE_ENTRIES);
	localparam logic [63:0] PiQ      = 64'h3243F6A8885A308D;
	localparam logic [63:0] HalfPiQ  = 64'h1921FB54442D1846;
	localparam logic [63:0] TermDiv [15] = '{
		64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272,
		64'd342, 64'd420, 64'd506, 64'd600, 64'd702, 64'd812, 64'd930
	};

	function automatic logic [63:0] qmul(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		return p[123:60];
	endfunction

	// {carrier, modulator} for one table entry
	function automatic logic [15:0] sine_entry(input int unsigned i);
		logic [63:0] num, x, r, x2, term, sum, hi, lo, mag, frac, car;
		logic neg;
		num = AngleNum * 64'(i);
		x = (num / Den) << 60;
		r = num % Den;
		for (int b = 59; b >= 0; b--) begin
			r = r << 1;
			if (r >= Den) begin
				r = r - Den;
				x[b] = 1'b1;
			end
		end
		neg = 1'b0;
		for (int n = 0; n < 2; n++) begin
			if (x >= PiQ) begin
				x = x - PiQ;
				neg = ~neg;
			end
		end
		if (x > HalfPiQ)
			x = PiQ - x;
		x2 = qmul(x, x);
		term = x;
		sum = x;
		for (int k = 0; k < 15; k++) begin
			term = qmul(term, x2) / TermDiv[k];
			if (k % 2 == 0)
				sum = sum - term;
			else
				sum = sum + term;
		end
		hi = sum >> 30;
		lo = sum & ((64'd1 << 30) - 64'd1);
		mag = (64'd127 * hi + ((64'd127 * lo) >> 30)) >> 30;
		frac = (64'd127 * sum) & ((64'd1 << 60) - 64'd1);
		if (neg) begin
			car = 64'd128 - mag - {63'd0, frac != 64'd0};
			return {car[7:0], 8'(64'd0 - mag)};
		end
		car = 64'd128 + mag;
		return {car[7:0], mag[7:0]};
	endfunction

	function automatic rom_t build_mod_rom();
		rom_t rom;
		logic [15:0] e;
		for (int unsigned i = 0; i < TABLE_ENTRIES; i++) begin
			e = sine_entry(i);
			rom[i] = e[7:0];
		end
		return rom;
	endfunction

	function automatic rom_t build_car_rom();
		rom_t rom;
		logic [15:0] e;
		for (int unsigned i = 0; i < TABLE_ENTRIES; i++) begin
			e = sine_entry(i);
			rom[i] = e[15:8];
		end
		return rom;
	endfunction

	localparam rom_t MOD_ROM = build_mod_rom();
	localparam rom_t CAR_ROM = build_car_rom();

endpackage

FILE: rtl/fm_dds_oscillator_top.sv
// Output: a result is presented in the cycle after its item is taken.
// Throughput: one item per cycle while item_stall is low; the carrier
// phase update (table read, shift, accumulate) completes in that cycle.
// Reset: phases, registers and the output valid clear asynchronously;
// the sine tables are constant and need no initialization.
module fm_dds_oscillator_top
	import fmdds_pkg::*;
#(
	parameter int unsigned PHASE_BITS = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [CFG_IDX_BITS-1:0]       cfg_index,
	input  logic [REG_BITS-1:0]           cfg_data,
	input  logic                          item_valid,
	output logic                          item_stall,
	input  logic                          tick,
	output logic                          result_valid,
	input  logic                          result_stall,
	output logic [SAMPLE_BITS-1:0]        level,
	output logic signed [SAMPLE_BITS-1:0] mod_sample
);

	cfg_t                   cfg;
	logic                   accept;
	logic                   full;
	logic [SAMPLE_BITS-1:0] level_d;
	logic [SAMPLE_BITS-1:0] mod_d;

	assign item_stall = full;
	assign accept     = item_valid & ~full;

	fmdds_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	fmdds_engine #(
		.PHASE_BITS (PHASE_BITS)
	) u_engine (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.advance (accept & tick),
		.level   (level_d),
		.mod_raw (mod_d)
	);

	fmdds_outreg u_outreg (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (accept),
		.level_d      (level_d),
		.mod_d        (mod_d),
		.full         (full),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.level        (level),
		.mod_sample   (mod_sample)
	);

endmodule

FILE: rtl/fmdds_cfg.sv
module fmdds_cfg
	import fmdds_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CFG_IDX_BITS-1:0] cfg_index,
	input  logic [REG_BITS-1:0]     cfg_data,
	output cfg_t                    cfg
);

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_MOD_INC: cfg_q.mod_inc <= cfg_data;
				REG_CAR_INC: cfg_q.car_inc <= cfg_data;
				REG_DEPTH:   cfg_q.depth   <= cfg_data[DEPTH_BITS-1:0];
				default: ;
			endcase
		end
	end

endmodule

FILE: rtl/fmdds_engine.sv
module fmdds_engine
	import fmdds_pkg::*;
#(
	parameter int unsigned PHASE_BITS = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  cfg_t                   cfg,
	input  logic                   advance,
	output logic [SAMPLE_BITS-1:0] level,
	output logic [SAMPLE_BITS-1:0] mod_raw
);

	logic [PHASE_BITS-1:0] mod_phase_q;
	logic [PHASE_BITS-1:0] car_phase_q;
	logic [PHASE_BITS-1:0] mod_inc;
	logic [PHASE_BITS-1:0] car_inc;
	logic [PHASE_BITS-1:0] mod_ext;
	logic [PHASE_BITS-1:0] step;
	logic [INDEX_BITS-1:0] mod_idx;
	logic [INDEX_BITS-1:0] car_idx;

	generate
		if (PHASE_BITS > REG_BITS) begin : g_wide
			assign mod_inc = {{(PHASE_BITS-REG_BITS){1'b0}}, cfg.mod_inc};
			assign car_inc = {{(PHASE_BITS-REG_BITS){1'b0}}, cfg.car_inc};
		end else begin : g_narrow
			assign mod_inc = cfg.mod_inc[PHASE_BITS-1:0];
			assign car_inc = cfg.car_inc[PHASE_BITS-1:0];
		end
	endgenerate

	assign mod_idx = mod_phase_q[PHASE_BITS-1 -: INDEX_BITS];
	assign car_idx = car_phase_q[PHASE_BITS-1 -: INDEX_BITS];
	assign mod_raw = MOD_ROM[mod_idx];
	assign level   = CAR_ROM[car_idx];

	// sign-extended sample, shifted, wraps at the phase width
	assign mod_ext = {{(PHASE_BITS-SAMPLE_BITS){mod_raw[SAMPLE_BITS-1]}}, mod_raw};
	assign step    = car_inc + (mod_ext << cfg.depth);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_phase_q <= '0;
			car_phase_q <= '0;
		end else if (advance) begin
			mod_phase_q <= mod_phase_q + mod_inc;
			car_phase_q <= car_phase_q + step;
		end
	end

endmodule

FILE: rtl/fmdds_outreg.sv
module fmdds_outreg
	import fmdds_pkg::*;
(
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          load,
	input  logic [SAMPLE_BITS-1:0]        level_d,
	input  logic [SAMPLE_BITS-1:0]        mod_d,
	output logic                          full,
	output logic                          result_valid,
	input  logic                          result_stall,
	output logic [SAMPLE_BITS-1:0]        level,
	output logic signed [SAMPLE_BITS-1:0] mod_sample
);

	logic                   valid_q;
	logic [SAMPLE_BITS-1:0] level_q;
	logic [SAMPLE_BITS-1:0] mod_q;

	// holding a result the sink has not taken yet
	assign full         = valid_q & result_stall;
	assign result_valid = valid_q;
	assign level        = level_q;
	assign mod_sample   = signed'(mod_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!result_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			level_q <= level_d;
			mod_q   <= mod_d;
		end
	end

endmodule
